// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that is checked on every rising edge outside of reset.
`define LDFB_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must hold in the first cycle after reset is released.
`define LDFB_ASSERT_AFTER_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) $past(rst) && !rst |-> prop) else $error(msg);

`endif

// ===== rtl/ldfb_pkg.sv =====
// ----------------------------------------------------------------------------
// ldfb_pkg
// Types, constants and pixel helpers of the line drawing frame buffer.
// ----------------------------------------------------------------------------
package ldfb_pkg;

   // Screen geometry. Each page holds eight pixel rows, one bit per row.
   localparam int SCREEN_WIDTH  = 128;
   localparam int PAGE_COUNT    = 8;
   localparam int PAGE_ROWS     = 8;
   localparam int BYTE_W        = 8;
   localparam int SCREEN_HEIGHT = PAGE_COUNT * PAGE_ROWS;
   localparam int STORE_DEPTH   = PAGE_COUNT * SCREEN_WIDTH;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int WIDE_W        = ADDR_W + 1;

   // Coordinate and Bresenham arithmetic widths.
   localparam int COORD_W = 10;
   localparam int DELTA_W = COORD_W + 1;
   localparam int ERR_W   = COORD_W + 3;
   localparam int E2_W    = ERR_W + 1;

   // Field widths of the request ports.
   localparam int CMD_W    = 2;
   localparam int PAGE_W   = 3;
   localparam int COLUMN_W = 7;
   localparam int COUNT_W  = 8;

   typedef enum logic [CMD_W-1:0] {
      OP_FILL  = 2'd0,
      OP_PIXEL = 2'd1,
      OP_LINE  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [BYTE_W-1:0]         byte_type;

   // Decoded request as it waits between the front and the back.
   typedef struct packed {
      op_type             op;
      coord_type          x;
      coord_type          y;
      coord_type          x_end;
      coord_type          y_end;
      logic [DELTA_W-1:0] dx;
      logic [DELTA_W-1:0] dy;
      logic               step_x_neg;
      logic               step_y_neg;
      byte_type           fill_value;
      addr_type           addr;
      logic               in_range;
   } cmd_type;

   // Control the back returns to the front.
   typedef struct packed {
      logic clearing;
      logic take;
   } back_status_type;

   // True when the point lies inside the screen.
   function automatic logic on_screen(input coord_type x, input coord_type y);
      logic x_ok;
      logic y_ok;
      x_ok = !x[COORD_W-1] && ({1'b0, x[COORD_W-2:0]} < COORD_W'(SCREEN_WIDTH));
      y_ok = !y[COORD_W-1] && ({1'b0, y[COORD_W-2:0]} < COORD_W'(SCREEN_HEIGHT));
      return x_ok && y_ok;
   endfunction

   // Store address of the byte holding an on-screen point.
   function automatic addr_type pixel_addr(input coord_type x, input coord_type y);
      logic [WIDE_W-1:0] wide;
      wide = WIDE_W'(y[COORD_W-2:3]) * WIDE_W'(SCREEN_WIDTH) + WIDE_W'(x[COORD_W-2:0]);
      return wide[ADDR_W-1:0];
   endfunction

   // Bit of the byte that holds the row of a point.
   function automatic byte_type pixel_mask(input coord_type y);
      byte_type mask;
      mask = byte_type'(1) << y[2:0];
      return mask;
   endfunction

endpackage

// ===== rtl/ldfb_ram.sv =====
// ----------------------------------------------------------------------------
// ldfb_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ldfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read of the same address.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/ldfb_front.sv =====
// ----------------------------------------------------------------------------
// ldfb_front
// Accepts requests, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ldfb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [ldfb_pkg::CMD_W-1:0]    req_cmd,
   input  ldfb_pkg::coord_type           req_x_start,
   input  ldfb_pkg::coord_type           req_y_start,
   input  ldfb_pkg::coord_type           req_x_end,
   input  ldfb_pkg::coord_type           req_y_end,
   input  ldfb_pkg::byte_type            req_fill_value,
   input  logic [ldfb_pkg::PAGE_W-1:0]   req_page_index,
   input  logic [ldfb_pkg::COLUMN_W-1:0] req_column_index,
   input  ldfb_pkg::back_status_type     status,
   output ldfb_pkg::cmd_type             head,
   output logic                          head_valid
);

   import ldfb_pkg::*;

   cmd_type            decoded;
   cmd_type            entry0_ff;
   cmd_type            entry0_in;
   cmd_type            entry1_ff;
   cmd_type            entry1_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               accept;
   logic [DELTA_W-1:0] diff_x;
   logic [DELTA_W-1:0] diff_y;
   logic [WIDE_W-1:0]  read_wide;
   logic               read_ok;

   // Signed differences of the endpoints and the byte address of a read.
   always_comb begin
      diff_x    = {req_x_end[COORD_W-1], req_x_end} - {req_x_start[COORD_W-1], req_x_start};
      diff_y    = {req_y_end[COORD_W-1], req_y_end} - {req_y_start[COORD_W-1], req_y_start};
      read_wide = WIDE_W'(req_page_index) * WIDE_W'(SCREEN_WIDTH) + WIDE_W'(req_column_index);
      read_ok   = ({2'b00, req_page_index} < 5'(PAGE_COUNT))
               && ({2'b00, req_column_index} < 9'(SCREEN_WIDTH));
   end

   // Decode. A single pixel runs as a line whose end is its start.
   always_comb begin
      decoded.op         = op_type'(req_cmd);
      decoded.x          = req_x_start;
      decoded.y          = req_y_start;
      decoded.x_end      = req_x_end;
      decoded.y_end      = req_y_end;
      decoded.dx         = diff_x[DELTA_W-1] ? -diff_x : diff_x;
      decoded.dy         = diff_y[DELTA_W-1] ? -diff_y : diff_y;
      decoded.step_x_neg = diff_x[DELTA_W-1] || (diff_x == '0);
      decoded.step_y_neg = diff_y[DELTA_W-1] || (diff_y == '0);
      decoded.fill_value = req_fill_value;
      decoded.addr       = read_wide[ADDR_W-1:0];
      decoded.in_range   = read_ok;
      case (decoded.op)
         OP_PIXEL: begin
            decoded.x_end      = req_x_start;
            decoded.y_end      = req_y_start;
            decoded.dx         = '0;
            decoded.dy         = '0;
            decoded.step_x_neg = 1'b1;
            decoded.step_y_neg = 1'b1;
         end
         OP_FILL, OP_LINE, OP_READ: begin
         end
         default: begin
         end
      endcase
   end

   // The queue refuses requests when both entries hold work or while the
   // store is being cleared after reset.
   assign full   = (count_ff == 2'd2) || status.clearing;
   assign accept = push && !full;

   // Queue update: entry 0 is always the oldest request.
   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_ff;
      case ({accept, status.take})
         2'b10: begin
            if (count_ff == 2'd0) begin
               entry0_in = decoded;
            end else begin
               entry1_in = decoded;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            entry0_in = entry1_ff;
            count_in  = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               entry0_in = decoded;
            end else begin
               entry0_in = entry1_ff;
               entry1_in = decoded;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign head       = entry0_ff;
   assign head_valid = (count_ff != 2'd0);

endmodule

// ===== rtl/ldfb_back.sv =====
// ----------------------------------------------------------------------------
// ldfb_back
// Sequencer that carries out fill, line, pixel and read requests on the store.
// ----------------------------------------------------------------------------
module ldfb_back (
   input  logic                         clock,
   input  logic                         reset,
   input  ldfb_pkg::cmd_type            head,
   input  logic                         head_valid,
   output ldfb_pkg::back_status_type    status,
   output logic                         ram_we,
   output ldfb_pkg::addr_type           ram_addr,
   output ldfb_pkg::byte_type           ram_wdata,
   input  ldfb_pkg::byte_type           ram_rdata,
   output logic                         empty,
   input  logic                         pop,
   output ldfb_pkg::byte_type           rsp_read_data,
   output logic [ldfb_pkg::COUNT_W-1:0] rsp_pixels_set
);

   import ldfb_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_LINE_PLOT,
      ST_LINE_WR,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   state_type           state_ff;
   state_type           state_in;
   cmd_type             cur_ff;
   cmd_type             cur_in;
   coord_type           x_ff;
   coord_type           x_in;
   coord_type           y_ff;
   coord_type           y_in;
   logic [ERR_W-1:0]    err_ff;
   logic [ERR_W-1:0]    err_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;
   addr_type            sweep_addr_ff;
   addr_type            sweep_addr_in;
   byte_type            sweep_value_ff;
   byte_type            sweep_value_in;
   logic                sweep_report_ff;
   logic                sweep_report_in;
   logic                clearing_ff;
   logic                clearing_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   byte_type            rsp_data_ff;
   byte_type            rsp_data_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [COUNT_W-1:0]  rsp_count_in;

   logic                take;
   logic                point_on;
   addr_type            point_addr;
   byte_type            point_mask;
   logic                at_end;
   logic signed [E2_W-1:0] e2;
   logic signed [E2_W-1:0] dx_ext;
   logic signed [E2_W-1:0] dy_ext;
   logic                move_x;
   logic                move_y;
   coord_type           x_next;
   coord_type           y_next;
   logic [ERR_W-1:0]    err_next;
   logic [COUNT_W-1:0]  count_sat;

   // Current point of the line and its Bresenham step.
   always_comb begin
      point_on   = on_screen(x_ff, y_ff);
      point_addr = pixel_addr(x_ff, y_ff);
      point_mask = pixel_mask(y_ff);
      at_end     = (x_ff == cur_ff.x_end) && (y_ff == cur_ff.y_end);
      e2         = $signed({err_ff, 1'b0});
      dx_ext     = $signed(E2_W'(cur_ff.dx));
      dy_ext     = $signed(E2_W'(cur_ff.dy));
      move_x     = e2 > -dy_ext;
      move_y     = e2 < dx_ext;
      x_next     = x_ff;
      y_next     = y_ff;
      err_next   = err_ff;
      if (move_x) begin
         x_next   = cur_ff.step_x_neg ? x_ff - coord_type'(1) : x_ff + coord_type'(1);
         err_next = err_next - ERR_W'(cur_ff.dy);
      end
      if (move_y) begin
         y_next   = cur_ff.step_y_neg ? y_ff - coord_type'(1) : y_ff + coord_type'(1);
         err_next = err_next + ERR_W'(cur_ff.dx);
      end
      count_sat = (count_ff == '1) ? count_ff : count_ff + COUNT_W'(1);
   end

   // A request is taken only while the result register is free.
   assign take = (state_ff == ST_IDLE) && head_valid && !rsp_valid_ff;

   // Store access for each state.
   always_comb begin
      ram_we    = 1'b0;
      ram_addr  = point_addr;
      ram_wdata = ram_rdata | point_mask;
      case (state_ff)
         ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_addr_ff;
            ram_wdata = sweep_value_ff;
         end
         ST_LINE_WR: begin
            ram_we = 1'b1;
         end
         ST_RD_ISSUE: begin
            ram_addr = cur_ff.addr;
         end
         ST_IDLE, ST_LINE_PLOT, ST_RD_WAIT: begin
         end
         default: begin
         end
      endcase
   end

   // Next state, request progress and result register.
   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      err_in          = err_ff;
      count_in        = count_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_value_in  = sweep_value_ff;
      sweep_report_in = sweep_report_ff;
      clearing_in     = clearing_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_count_in    = rsp_count_ff;

      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cur_in   = head;
               x_in     = head.x;
               y_in     = head.y;
               err_in   = ERR_W'(head.dx) - ERR_W'(head.dy);
               count_in = '0;
               case (head.op)
                  OP_FILL: begin
                     sweep_addr_in   = '0;
                     sweep_value_in  = head.fill_value;
                     sweep_report_in = 1'b1;
                     state_in        = ST_SWEEP;
                  end
                  OP_PIXEL, OP_LINE: begin
                     state_in = ST_LINE_PLOT;
                  end
                  OP_READ: begin
                     state_in = ST_RD_ISSUE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            sweep_addr_in = sweep_addr_ff + addr_type'(1);
            if (sweep_addr_ff == addr_type'(STORE_DEPTH - 1)) begin
               clearing_in = 1'b0;
               state_in    = ST_IDLE;
               if (sweep_report_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  rsp_count_in = '0;
               end
            end
         end
         ST_LINE_PLOT: begin
            // On-screen points read their byte; others advance at once.
            if (point_on) begin
               count_in = count_sat;
               state_in = ST_LINE_WR;
            end else if (at_end) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end else begin
               x_in   = x_next;
               y_in   = y_next;
               err_in = err_next;
            end
         end
         ST_LINE_WR: begin
            if (at_end) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end else begin
               x_in     = x_next;
               y_in     = y_next;
               err_in   = err_next;
               state_in = ST_LINE_PLOT;
            end
         end
         ST_RD_ISSUE: begin
            if (cur_ff.in_range) begin
               state_in = ST_RD_WAIT;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_count_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = ram_rdata;
            rsp_count_in = '0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs. Reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SWEEP;
         sweep_addr_ff   <= '0;
         sweep_value_ff  <= '0;
         sweep_report_ff <= 1'b0;
         clearing_ff     <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sweep_addr_ff   <= sweep_addr_in;
         sweep_value_ff  <= sweep_value_in;
         sweep_report_ff <= sweep_report_in;
         clearing_ff     <= clearing_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      err_ff       <= err_in;
      count_ff     <= count_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign status.clearing = clearing_ff;
   assign status.take     = take;
   assign empty           = !rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_pixels_set  = rsp_count_ff;

endmodule

// ===== rtl/line_draw_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// line_draw_frame_buffer
// Monochrome page-organized frame store with fill, pixel, line and read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter through a queue-style port: a request is taken on a rising
//   edge with push high and full low. Results leave the same way: the oldest
//   result is shown while empty is low and is taken on an edge with pop high.
//   Every request gives exactly one result.
// Steps of each request, set by the single store port and the back's sequencer:
//   fill      one byte written per cycle across all STORE_DEPTH bytes.
//   line      each on-screen point is read in ST_LINE_PLOT and written in
//             ST_LINE_WR; an off-screen point only passes ST_LINE_PLOT.
//   pixel     the same path as a one-point line.
//   read      ST_RD_ISSUE addresses the store and ST_RD_WAIT takes the byte.
// Throughput: one request at a time in the back; two decoded requests queue
//   in front of it, and requests are accepted while a result waits.
// Reset: a clearing pass writes zero to all STORE_DEPTH bytes; full stays
//   high until it ends.
// Stall: when pop stays low the result is held and the back waits; the
//   front keeps taking requests until its queue is full.
// ----------------------------------------------------------------------------
module line_draw_frame_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [ldfb_pkg::CMD_W-1:0]    req_cmd,
   input  ldfb_pkg::coord_type           req_x_start,
   input  ldfb_pkg::coord_type           req_y_start,
   input  ldfb_pkg::coord_type           req_x_end,
   input  ldfb_pkg::coord_type           req_y_end,
   input  ldfb_pkg::byte_type            req_fill_value,
   input  logic [ldfb_pkg::PAGE_W-1:0]   req_page_index,
   input  logic [ldfb_pkg::COLUMN_W-1:0] req_column_index,
   output logic                          empty,
   input  logic                          pop,
   output ldfb_pkg::byte_type            rsp_read_data,
   output logic [ldfb_pkg::COUNT_W-1:0]  rsp_pixels_set
);

   import ldfb_pkg::*;

   cmd_type         head;
   logic            head_valid;
   back_status_type status;
   logic            ram_we;
   addr_type        ram_addr;
   byte_type        ram_wdata;
   byte_type        ram_rdata;

   // Request decode and queue.
   ldfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_fill_value   (req_fill_value),
      .req_page_index   (req_page_index),
      .req_column_index (req_column_index),
      .status           (status),
      .head             (head),
      .head_valid       (head_valid)
   );

   // Sequencer and result register.
   ldfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .status         (status),
      .ram_we         (ram_we),
      .ram_addr       (ram_addr),
      .ram_wdata      (ram_wdata),
      .ram_rdata      (ram_rdata),
      .empty          (empty),
      .pop            (pop),
      .rsp_read_data  (rsp_read_data),
      .rsp_pixels_set (rsp_pixels_set)
   );

   // Frame store.
   ldfb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule

// ===== rtl/ldfb_checker.sv =====
// ----------------------------------------------------------------------------
// ldfb_checker
// Port-level assertions for the line drawing frame buffer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldfb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          push,
   input logic                          full,
   input logic [ldfb_pkg::CMD_W-1:0]    req_cmd,
   input ldfb_pkg::coord_type           req_x_start,
   input ldfb_pkg::coord_type           req_y_start,
   input ldfb_pkg::coord_type           req_x_end,
   input ldfb_pkg::coord_type           req_y_end,
   input ldfb_pkg::byte_type            req_fill_value,
   input logic [ldfb_pkg::PAGE_W-1:0]   req_page_index,
   input logic [ldfb_pkg::COLUMN_W-1:0] req_column_index,
   input logic                          empty,
   input logic                          pop,
   input ldfb_pkg::byte_type            rsp_read_data,
   input logic [ldfb_pkg::COUNT_W-1:0]  rsp_pixels_set
);

   // After reset the clearing pass blocks requests and no result is shown.
   `LDFB_ASSERT_AFTER_RESET(a_reset_clears, clock, reset, full && empty, "reset state wrong")

   // A result waiting for pop holds its value.
   `LDFB_ASSERT_CLK(a_rsp_hold, clock, reset, !empty && !pop |=> !empty && $stable(rsp_read_data) && $stable(rsp_pixels_set), "stalled result changed")

   // Only a read returns data, and a read sets no pixels.
   `LDFB_ASSERT_CLK(a_rsp_exclusive, clock, reset, !empty |-> (rsp_read_data == 0 || rsp_pixels_set == 0), "read data and pixel count both set")

   // A taken result is not followed by another in the next cycle.
   `LDFB_ASSERT_CLK(a_rsp_gap, clock, reset, pop && !empty |=> empty, "result repeated after pop")

endmodule

bind line_draw_frame_buffer ldfb_checker u_checker (.*);
